>>> rtl/core/soa_pkg.sv
// shared constants and types for the slab object allocator
`default_nettype none
package soa_pkg;

	localparam int NUM_SLABS_DEF   = 16;
	localparam int MAX_OBJECTS_DEF = 1024;

	localparam int ADDR_W    = 48;
	localparam int SIZE_W    = 14;
	localparam int OPS_W     = 11;
	localparam int STRIDE_W  = 25;
	localparam int BASE_W    = 50;
	localparam int STAMP_W   = 16;
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;
	localparam int CFG_W     = 2;
	localparam int SLAB_IDX_W = 4;
	localparam int OBJ_IDX_W  = 10;

	localparam logic [STAMP_W-1:0] STAMP_LIMIT = 16'hFFFF;

	localparam logic [SIZE_W-1:0]   OBJECT_SIZE_RST = 14'd8;
	localparam logic [OPS_W-1:0]    OBJECTS_RST     = 11'd1024;
	localparam logic [STRIDE_W-1:0] STRIDE_RST      = 25'd8192;
	localparam logic [ADDR_W-1:0]   REGION_RST      = 48'd0;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_OUT_OF_MEM   = 2'd1,
		ST_INVALID      = 2'd2,
		ST_DOUBLE_FREE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		LIST_UNUSED  = 2'd0,
		LIST_VACANT  = 2'd1,
		LIST_PARTIAL = 2'd2,
		LIST_FULL    = 2'd3
	} list_t;

	typedef enum logic [CFG_W-1:0] {
		CFG_OBJECT_SIZE = 2'd0,
		CFG_OBJECTS     = 2'd1,
		CFG_STRIDE      = 2'd2,
		CFG_REGION      = 2'd3
	} cfg_idx_t;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

endpackage
`default_nettype wire

>>> rtl/core/soa_ram.sv
// generic single-port ram with registered read
`default_nettype none
module soa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

>>> rtl/core/soa_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module soa_div #(
	parameter int DW = 25,
	parameter int VW = 14
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic      [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   rem_sh;
	logic          ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[DW-1]};
		ge     = rem_sh >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				cnt_q <= CW'(DW);
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= ge ? VW'(rem_sh - {1'b0, divisor}) : VW'(rem_sh);
				quo_q <= {quo_q[DW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/slab_object_allocator_unit.sv
// slab object allocator top level: request sequencer, slab table and bitmap memory
//
// channel   direction  handshake                 payload
// request   in         start high, busy low      action, address
// result    out        done strobe, one cycle    status, object_address, slab_index, object_index
// config    in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
// after reset the bitmap memory is cleared one word a cycle, with busy high; configuration
// writes are taken throughout.
// an allocate scans the slab table, then reads bitmap words up to the first free slot, then
// updates the lists; a free scans the table, divides the offset by the object size, then
// checks the bitmap and updates the lists. a list move may add a stamp renumbering pass.
// the result cannot be stalled.
`default_nettype none
module slab_object_allocator_unit
	import soa_pkg::*;
#(
	parameter int NUM_SLABS   = NUM_SLABS_DEF,
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  action,
	input  wire logic [ADDR_W-1:0]     address,
	output logic                       done,
	output logic      [1:0]            status,
	output logic      [ADDR_W-1:0]     object_address,
	output logic      [SLAB_IDX_W-1:0] slab_index,
	output logic      [OBJ_IDX_W-1:0]  object_index,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      cfg_index,
	input  wire logic [ADDR_W-1:0]     cfg_data
);

	localparam int SLAB_W   = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
	localparam int GROW_W   = $clog2(NUM_SLABS + 1);
	localparam int WORDS    = (MAX_OBJECTS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SLOT_W   = WORD_W + BIT_W;
	localparam int CNT_W    = $clog2(MAX_OBJECTS + 1);
	localparam int SPAN_W   = SIZE_W + CNT_W;
	localparam int BM_DEPTH = NUM_SLABS * WORDS;
	localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;

	typedef enum logic [15:0] {
		S_CLEAR  = 16'h0001,
		S_IDLE   = 16'h0002,
		S_PREP   = 16'h0004,
		S_SCAN   = 16'h0008,
		S_DECIDE = 16'h0010,
		S_PLACE  = 16'h0020,
		S_RENUM  = 16'h0040,
		S_RANK   = 16'h0080,
		S_BRD    = 16'h0100,
		S_BCHK   = 16'h0200,
		S_ACNT   = 16'h0400,
		S_AADDR  = 16'h0800,
		S_DIV    = 16'h1000,
		S_FRD    = 16'h2000,
		S_FCHK   = 16'h4000,
		S_OUT    = 16'h8000
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0]   object_size_q;
	logic [OPS_W-1:0]    objects_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [ADDR_W-1:0]   region_q;

	list_t              list_q  [NUM_SLABS];
	logic [STAMP_W-1:0] stamp_q [NUM_SLABS];
	logic [CNT_W-1:0]   used_q  [NUM_SLABS];
	logic               rdone_q [NUM_SLABS];
	logic [STAMP_W-1:0] counter_q;
	logic [GROW_W-1:0]  grown_q;

	logic               action_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [SLAB_W-1:0]  idx_q;
	logic [BASE_W-1:0]  base_q;
	logic [BASE_W-1:0]  grow_base_q;
	logic [SPAN_W-1:0]  span_q;

	logic               cf_q [3];
	logic [STAMP_W-1:0] cs_q [3];
	logic [SLAB_W-1:0]  ci_q [3];
	logic [CNT_W-1:0]   cc_q [3];
	logic [BASE_W-1:0]  cb_q [3];

	logic [SLAB_W-1:0]  s_q;
	logic [CNT_W-1:0]   scnt_q;
	logic [BASE_W-1:0]  sbase_q;
	list_t              place_list_q;
	logic               ret_out_q;
	logic [WORD_W-1:0]  w_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SPAN_W-1:0]  off_q;

	logic               mf_q;
	logic [STAMP_W-1:0] mstamp_q;
	logic [SLAB_W-1:0]  midx_q;
	logic [STAMP_W-1:0] rank_q;

	logic [BM_AW-1:0]   clr_q;

	logic                done_q;
	status_t             status_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [SLAB_IDX_W-1:0] res_slab_q;
	logic [OBJ_IDX_W-1:0]  res_obj_q;

	logic [SIZE_W-1:0]    size_eff;
	logic [CNT_W-1:0]     cnt_eff;
	logic [BASE_W-1:0]    addr_ext;
	logic [BASE_W-1:0]    diff;
	logic                 match;
	logic [1:0]           lk;
	list_t                cur_list;
	logic                 bc_found;
	logic [BIT_W-1:0]     bc_bit;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] bm_rdata;
	logic [WORD_BITS-1:0] bm_wdata;
	logic [BM_AW-1:0]     bm_addr;
	logic                 bm_we;
	logic                 free_bit;
	logic [CNT_W-1:0]     dec_cnt;
	logic                 div_start;
	logic [SPAN_W-1:0]    div_dividend;
	logic                 div_done;
	logic [SPAN_W-1:0]    div_quo;
	logic [1:0]           fk;
	logic                 f_any;

	always_comb begin
		size_eff = (object_size_q == '0) ? SIZE_W'(1) : object_size_q;
		if (32'(objects_q) > MAX_OBJECTS) begin
			cnt_eff = CNT_W'(MAX_OBJECTS);
		end else begin
			cnt_eff = CNT_W'(objects_q);
		end
		addr_ext = BASE_W'(addr_q);
		diff     = addr_ext - base_q;
		match    = (action_q == ACT_ALLOC) ||
			((addr_ext >= base_q) && (diff < BASE_W'(span_q)));
		cur_list = list_q[idx_q];
		lk       = 2'(cur_list) - 2'd1;
	end

	// free candidate priority: partial, full, empty
	always_comb begin
		f_any = 1'b1;
		if (cf_q[1]) begin
			fk = 2'd1;
		end else if (cf_q[2]) begin
			fk = 2'd2;
		end else if (cf_q[0]) begin
			fk = 2'd0;
		end else begin
			fk    = 2'd0;
			f_any = 1'b0;
		end
		div_dividend = SPAN_W'(addr_ext - cb_q[fk]);
		div_start    = (state_q == S_DECIDE) && (action_q == ACT_FREE) && f_any;
	end

	// lowest free slot of the word just read
	always_comb begin
		bc_found = 1'b0;
		bc_bit   = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!bm_rdata[b] && ((32'(w_q) * WORD_BITS + b) < 32'(cnt_eff))) begin
				bc_found = 1'b1;
				bc_bit   = BIT_W'(b);
			end
		end
	end

	always_comb begin
		free_bit = bm_rdata[slot_q[BIT_W-1:0]];
		dec_cnt  = (scnt_q != '0) ? scnt_q - 1'b1 : scnt_q;
		if (state_q == S_BCHK) begin
			bit_mask = WORD_BITS'(1) << bc_bit;
		end else begin
			bit_mask = WORD_BITS'(1) << slot_q[BIT_W-1:0];
		end
		if (state_q == S_CLEAR) begin
			bm_addr  = clr_q;
			bm_wdata = '0;
			bm_we    = 1'b1;
		end else begin
			bm_addr  = BM_AW'(32'(s_q) * WORDS + 32'(w_q));
			bm_wdata = (state_q == S_BCHK) ? (bm_rdata | bit_mask) : (bm_rdata & ~bit_mask);
			bm_we    = ((state_q == S_BCHK) && bc_found) || ((state_q == S_FCHK) && free_bit);
		end
	end

	soa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (BM_DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.addr  (bm_addr),
		.wdata (bm_wdata),
		.rdata (bm_rdata)
	);

	soa_div #(
		.DW (SPAN_W),
		.VW (SIZE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (size_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_size_q <= OBJECT_SIZE_RST;
			objects_q     <= OBJECTS_RST;
			stride_q      <= STRIDE_RST;
			region_q      <= REGION_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OBJECT_SIZE: object_size_q <= SIZE_W'(cfg_data);
				CFG_OBJECTS:     objects_q     <= OPS_W'(cfg_data);
				CFG_STRIDE:      stride_q      <= STRIDE_W'(cfg_data);
				CFG_REGION:      region_q      <= cfg_data;
				default:         region_q      <= region_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			for (int i = 0; i < NUM_SLABS; i++) begin
				list_q[i]  <= LIST_UNUSED;
				stamp_q[i] <= '0;
				used_q[i]  <= '0;
				rdone_q[i] <= 1'b0;
			end
			for (int k = 0; k < 3; k++) begin
				cf_q[k] <= 1'b0;
				cs_q[k] <= '0;
				ci_q[k] <= '0;
				cc_q[k] <= '0;
				cb_q[k] <= '0;
			end
			counter_q    <= '0;
			grown_q      <= '0;
			action_q     <= ACT_ALLOC;
			addr_q       <= '0;
			idx_q        <= '0;
			base_q       <= '0;
			grow_base_q  <= '0;
			span_q       <= '0;
			s_q          <= '0;
			scnt_q       <= '0;
			sbase_q      <= '0;
			place_list_q <= LIST_UNUSED;
			ret_out_q    <= 1'b0;
			w_q          <= '0;
			slot_q       <= '0;
			off_q        <= '0;
			mf_q         <= 1'b0;
			mstamp_q     <= '0;
			midx_q       <= '0;
			rank_q       <= '0;
			clr_q        <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			res_addr_q   <= '0;
			res_slab_q   <= '0;
			res_obj_q    <= '0;
		end else begin
			done_q <= (state_q == S_OUT);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BM_AW'(BM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						action_q <= action;
						addr_q   <= address;
						state_q  <= S_PREP;
					end
				end
				S_PREP: begin
					span_q <= SPAN_W'(size_eff) * SPAN_W'(cnt_eff);
					base_q <= BASE_W'(region_q);
					idx_q  <= '0;
					for (int k = 0; k < 3; k++) begin
						cf_q[k] <= 1'b0;
					end
					if ((action_q == ACT_ALLOC) && (cnt_eff == '0)) begin
						status_q   <= ST_OUT_OF_MEM;
						res_addr_q <= '0;
						res_slab_q <= '0;
						res_obj_q  <= '0;
						state_q    <= S_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if ((cur_list != LIST_UNUSED) && match &&
						(!cf_q[lk] || (stamp_q[idx_q] > cs_q[lk]))) begin
						cf_q[lk] <= 1'b1;
						cs_q[lk] <= stamp_q[idx_q];
						ci_q[lk] <= idx_q;
						cc_q[lk] <= used_q[idx_q];
						cb_q[lk] <= base_q;
					end
					if (GROW_W'(idx_q) == grown_q) begin
						grow_base_q <= base_q;
					end
					base_q <= base_q + BASE_W'(stride_q);
					idx_q  <= idx_q + 1'b1;
					if (idx_q == SLAB_W'(NUM_SLABS - 1)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					w_q <= '0;
					if (action_q == ACT_ALLOC) begin
						if (cf_q[1]) begin
							s_q     <= ci_q[1];
							scnt_q  <= cc_q[1];
							sbase_q <= cb_q[1];
							state_q <= S_BRD;
						end else if (cf_q[0]) begin
							s_q     <= ci_q[0];
							scnt_q  <= cc_q[0];
							sbase_q <= cb_q[0];
							state_q <= S_BRD;
						end else if (32'(grown_q) < NUM_SLABS) begin
							s_q          <= SLAB_W'(grown_q);
							scnt_q       <= '0;
							sbase_q      <= grow_base_q;
							grown_q      <= grown_q + 1'b1;
							place_list_q <= LIST_VACANT;
							ret_out_q    <= 1'b0;
							state_q      <= S_PLACE;
						end else begin
							status_q   <= ST_OUT_OF_MEM;
							res_addr_q <= '0;
							res_slab_q <= '0;
							res_obj_q  <= '0;
							state_q    <= S_OUT;
						end
					end else if (f_any) begin
						s_q     <= ci_q[fk];
						scnt_q  <= cc_q[fk];
						sbase_q <= cb_q[fk];
						state_q <= S_DIV;
					end else begin
						status_q   <= ST_INVALID;
						res_addr_q <= addr_q;
						res_slab_q <= '0;
						res_obj_q  <= '0;
						state_q    <= S_OUT;
					end
				end
				S_PLACE: begin
					if (counter_q >= STAMP_LIMIT) begin
						idx_q   <= '0;
						rank_q  <= '0;
						mf_q    <= 1'b0;
						state_q <= S_RENUM;
					end else begin
						list_q[s_q]  <= place_list_q;
						stamp_q[s_q] <= counter_q;
						counter_q    <= counter_q + 1'b1;
						state_q      <= ret_out_q ? S_OUT : S_BRD;
					end
				end
				S_RENUM: begin
					if ((cur_list != LIST_UNUSED) && !rdone_q[idx_q] &&
						(!mf_q || (stamp_q[idx_q] < mstamp_q))) begin
						mf_q     <= 1'b1;
						mstamp_q <= stamp_q[idx_q];
						midx_q   <= idx_q;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == SLAB_W'(NUM_SLABS - 1)) begin
						state_q <= S_RANK;
					end
				end
				S_RANK: begin
					idx_q <= '0;
					mf_q  <= 1'b0;
					if (mf_q) begin
						stamp_q[midx_q] <= rank_q;
						rdone_q[midx_q] <= 1'b1;
						rank_q          <= rank_q + 1'b1;
						state_q         <= S_RENUM;
					end else begin
						counter_q <= rank_q;
						for (int i = 0; i < NUM_SLABS; i++) begin
							rdone_q[i] <= 1'b0;
						end
						state_q <= S_PLACE;
					end
				end
				S_BRD: begin
					state_q <= S_BCHK;
				end
				S_BCHK: begin
					if (bc_found) begin
						slot_q  <= {w_q, bc_bit};
						state_q <= S_ACNT;
					end else if ((32'(w_q) + 1) * WORD_BITS < 32'(cnt_eff)) begin
						w_q     <= w_q + 1'b1;
						state_q <= S_BRD;
					end else begin
						status_q   <= ST_OUT_OF_MEM;
						res_addr_q <= '0;
						res_slab_q <= '0;
						res_obj_q  <= '0;
						state_q    <= S_OUT;
					end
				end
				S_ACNT: begin
					used_q[s_q] <= scnt_q + 1'b1;
					scnt_q      <= scnt_q + 1'b1;
					off_q       <= SPAN_W'(size_eff) * SPAN_W'(slot_q);
					state_q     <= S_AADDR;
				end
				S_AADDR: begin
					status_q   <= ST_OK;
					res_addr_q <= ADDR_W'(sbase_q + BASE_W'(off_q));
					res_slab_q <= SLAB_IDX_W'(s_q);
					res_obj_q  <= OBJ_IDX_W'(slot_q);
					ret_out_q  <= 1'b1;
					if (scnt_q >= cnt_eff) begin
						place_list_q <= LIST_FULL;
						state_q      <= S_PLACE;
					end else if (scnt_q == CNT_W'(1)) begin
						place_list_q <= LIST_PARTIAL;
						state_q      <= S_PLACE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (32'(div_quo) >= 32'(cnt_eff)) begin
							status_q   <= ST_INVALID;
							res_addr_q <= addr_q;
							res_slab_q <= '0;
							res_obj_q  <= '0;
							state_q    <= S_OUT;
						end else begin
							slot_q  <= SLOT_W'(div_quo);
							w_q     <= WORD_W'(div_quo >> BIT_W);
							state_q <= S_FRD;
						end
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					res_addr_q <= addr_q;
					res_slab_q <= SLAB_IDX_W'(s_q);
					res_obj_q  <= OBJ_IDX_W'(slot_q);
					ret_out_q  <= 1'b1;
					if (!free_bit) begin
						status_q <= ST_DOUBLE_FREE;
						state_q  <= S_OUT;
					end else begin
						status_q    <= ST_OK;
						used_q[s_q] <= dec_cnt;
						if (dec_cnt == '0) begin
							place_list_q <= LIST_VACANT;
							state_q      <= S_PLACE;
						end else if (dec_cnt + 1'b1 == cnt_eff) begin
							place_list_q <= LIST_PARTIAL;
							state_q      <= S_PLACE;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign cfg_ready      = 1'b1;
	assign done           = done_q;
	assign status         = status_q;
	assign object_address = res_addr_q;
	assign slab_index     = res_slab_q;
	assign object_index   = res_obj_q;

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in work");

	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_OUT_OF_MEM)) |->
		(object_address == '0) && (slab_index == '0) && (object_index == '0))
		else $error("out of memory result carries non-zero fields");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the slab object allocator: directed and random requests, mirrored allocator state
`default_nettype none
module testbench;
	import soa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLABS = 16;
	localparam int SLOTS = 1024;
	localparam int WATCHDOG_LIMIT = 50000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic              act;
		logic [ADDR_W-1:0] addr;
	} request_t;

	typedef struct {
		status_t               st;
		logic [ADDR_W-1:0]     addr;
		logic [SLAB_IDX_W-1:0] slab;
		logic [OBJ_IDX_W-1:0]  obj;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic action = ACT_ALLOC;
	logic [ADDR_W-1:0] address = '0;
	logic cfg_valid = 1'b0;
	logic [CFG_W-1:0] cfg_index = CFG_OBJECT_SIZE;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic busy, done, cfg_ready;
	logic [1:0] status;
	logic [ADDR_W-1:0] object_address;
	logic [SLAB_IDX_W-1:0] slab_index;
	logic [OBJ_IDX_W-1:0] object_index;

	slab_object_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.address(address), .done(done), .status(status), .object_address(object_address),
		.slab_index(slab_index), .object_index(object_index), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// allocator mirror
	logic [SIZE_W-1:0]   size_reg = OBJECT_SIZE_RST;
	logic [OPS_W-1:0]    count_reg = OBJECTS_RST;
	logic [STRIDE_W-1:0] stride_reg = STRIDE_RST;
	logic [ADDR_W-1:0]   region_reg = REGION_RST;
	bit    slot_used [SLABS][SLOTS];
	int    in_use [SLABS];
	list_t member [SLABS];
	int    stamp [SLABS];
	int    stamp_ctr = 0;
	int    grown = 0;

	request_t pending_reqs[$];
	outcome_t predicted_results[$];
	int live_objs[$];
	int freed_objs[$];
	int fail_count = 0;
	int status_seen [4];
	int items_done = 0;
	bit no_gaps = 1'b0;
	int quiet_cycles = 0;

	function automatic longint unsigned eff_size();
		return (size_reg == 0) ? 64'd1 : 64'(size_reg);
	endfunction

	function automatic int eff_count();
		return (count_reg > SLOTS) ? SLOTS : int'(count_reg);
	endfunction

	function automatic longint unsigned base_of(int s);
		return 64'(region_reg) + 64'(s) * 64'(stride_reg);
	endfunction

	function automatic void renumber_stamps();
		int rank [SLABS];
		int listed;
		listed = 0;
		for (int i = 0; i < SLABS; i++) begin
			rank[i] = 0;
			if (member[i] != LIST_UNUSED) begin
				listed++;
				for (int j = 0; j < SLABS; j++)
					if (member[j] != LIST_UNUSED && stamp[j] < stamp[i]) rank[i]++;
			end
		end
		for (int i = 0; i < SLABS; i++)
			if (member[i] != LIST_UNUSED) stamp[i] = rank[i];
		stamp_ctr = listed;
	endfunction

	function automatic void move_slab(int s, list_t l);
		if (stamp_ctr >= 65535) renumber_stamps();
		member[s] = l;
		stamp[s] = stamp_ctr;
		stamp_ctr++;
	endfunction

	function automatic int head_of(list_t l, bit match, longint unsigned a);
		int best;
		longint unsigned span, b;
		best = -1;
		span = eff_size() * 64'(eff_count());
		for (int s = 0; s < SLABS; s++) begin
			if (member[s] != l) continue;
			if (match) begin
				b = base_of(s);
				if (a < b || a - b >= span) continue;
			end
			if (best < 0 || stamp[s] > stamp[best]) best = s;
		end
		return best;
	endfunction

	function automatic void drop_live(int key);
		foreach (live_objs[i])
			if (live_objs[i] == key) begin
				live_objs.delete(i);
				return;
			end
	endfunction

	function automatic outcome_t allocator_predict(request_t rq);
		outcome_t r;
		int cnt, s, slot;
		longint unsigned a, off;
		cnt = eff_count();
		r.st = ST_OK;
		r.addr = '0;
		r.slab = '0;
		r.obj = '0;
		if (rq.act == ACT_ALLOC) begin
			if (cnt == 0) begin
				r.st = ST_OUT_OF_MEM;
				return r;
			end
			s = head_of(LIST_PARTIAL, 1'b0, 0);
			if (s < 0) s = head_of(LIST_VACANT, 1'b0, 0);
			if (s < 0) begin
				if (grown >= SLABS) begin
					r.st = ST_OUT_OF_MEM;
					return r;
				end
				s = grown;
				grown++;
				move_slab(s, LIST_VACANT);
			end
			slot = cnt;
			for (int i = 0; i < cnt; i++)
				if (!slot_used[s][i]) begin
					slot = i;
					break;
				end
			if (slot >= cnt) begin
				r.st = ST_OUT_OF_MEM;
				return r;
			end
			slot_used[s][slot] = 1'b1;
			in_use[s]++;
			if (in_use[s] >= cnt) move_slab(s, LIST_FULL);
			else if (in_use[s] == 1) move_slab(s, LIST_PARTIAL);
			r.addr = ADDR_W'(base_of(s) + eff_size() * 64'(slot));
			r.slab = SLAB_IDX_W'(s);
			r.obj = OBJ_IDX_W'(slot);
			live_objs.push_back(s * SLOTS + slot);
			return r;
		end
		a = 64'(rq.addr);
		r.addr = rq.addr;
		s = head_of(LIST_PARTIAL, 1'b1, a);
		if (s < 0) s = head_of(LIST_FULL, 1'b1, a);
		if (s < 0) s = head_of(LIST_VACANT, 1'b1, a);
		if (s < 0) begin
			r.st = ST_INVALID;
			return r;
		end
		off = (a - base_of(s)) / eff_size();
		if (off >= 64'(cnt)) begin
			r.st = ST_INVALID;
			return r;
		end
		slot = int'(off);
		r.slab = SLAB_IDX_W'(s);
		r.obj = OBJ_IDX_W'(slot);
		if (!slot_used[s][slot]) begin
			r.st = ST_DOUBLE_FREE;
			return r;
		end
		slot_used[s][slot] = 1'b0;
		if (in_use[s] > 0) in_use[s]--;
		if (in_use[s] == 0) move_slab(s, LIST_VACANT);
		else if (in_use[s] + 1 == cnt) move_slab(s, LIST_PARTIAL);
		drop_live(s * SLOTS + slot);
		freed_objs.push_back(s * SLOTS + slot);
		if (freed_objs.size() > 64) void'(freed_objs.pop_front());
		return r;
	endfunction

	// request driver
	always @(posedge clk) begin
		logic launch;
		request_t rq;
		launch = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				predicted_results.push_back(allocator_predict('{act: action, addr: address}));
				items_done++;
				launch = 1'b1;
			end else if (!start) begin
				launch = 1'b1;
			end
			if (launch) begin
				if (pending_reqs.size() > 0 && (no_gaps || $urandom_range(99) >= 32)) begin
					rq = pending_reqs.pop_front();
					start <= 1'b1;
					action <= rq.act;
					address <= rq.addr;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (done) begin
				if (predicted_results.size() == 0) begin
					$error("result with nothing outstanding: status %0d", status);
					fail_count++;
				end else begin
					e = predicted_results.pop_front();
					status_seen[e.st]++;
					if (status !== e.st) begin
						$error("status expected %0d actual %0d", e.st, status);
						fail_count++;
					end
					if (object_address !== e.addr) begin
						$error("object_address expected %h actual %h", e.addr, object_address);
						fail_count++;
					end
					if (slab_index !== e.slab) begin
						$error("slab_index expected %0d actual %0d", e.slab, slab_index);
						fail_count++;
					end
					if (object_index !== e.obj) begin
						$error("object_index expected %0d actual %0d", e.obj, object_index);
						fail_count++;
					end
				end
			end
			if (done || (start && !busy) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", predicted_results.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [ADDR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_OBJECT_SIZE: size_reg = val[SIZE_W-1:0];
			CFG_OBJECTS:     count_reg = val[OPS_W-1:0];
			CFG_STRIDE:      stride_reg = val[STRIDE_W-1:0];
			default:         region_reg = val;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || predicted_results.size() > 0 || start) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [ADDR_W-1:0] sz, logic [ADDR_W-1:0] cnt,
			logic [ADDR_W-1:0] strd, logic [ADDR_W-1:0] rgn);
		wait_idle();
		write_reg(CFG_OBJECT_SIZE, sz);
		write_reg(CFG_OBJECTS, cnt);
		write_reg(CFG_STRIDE, strd);
		write_reg(CFG_REGION, rgn);
	endtask

	function automatic logic [ADDR_W-1:0] key_addr(int key);
		return ADDR_W'(base_of(key / SLOTS) + eff_size() * 64'(key % SLOTS));
	endfunction

	task automatic push_random(int n);
		request_t rq;
		int r;
		for (int k = 0; k < n; k++) begin
			while (pending_reqs.size() > 0) @(posedge clk);
			r = $urandom_range(99);
			rq.act = ACT_FREE;
			if (r < 45 || (live_objs.size() == 0 && r < 80)) begin
				rq.act = ACT_ALLOC;
				rq.addr = ADDR_W'({$urandom, $urandom});
			end else if (r < 80)
				rq.addr = key_addr(live_objs[$urandom_range(live_objs.size() - 1)]);
			else if (r < 88 && freed_objs.size() > 0)
				rq.addr = key_addr(freed_objs[$urandom_range(freed_objs.size() - 1)]);
			else if (r < 95)
				rq.addr = ADDR_W'(base_of($urandom_range(SLABS)) + 64'($urandom_range(stride_reg)));
			else
				rq.addr = ADDR_W'({$urandom, $urandom});
			pending_reqs.push_back(rq);
		end
	endtask

	initial begin
		for (int s = 0; s < SLABS; s++) begin
			in_use[s] = 0;
			member[s] = LIST_UNUSED;
			stamp[s] = 0;
		end
		for (int i = 0; i < 4; i++) status_seen[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero size, sixteen slots, contiguous slabs
		set_config(0, 16, 16, 0);
		for (int i = 0; i < 17; i++) pending_reqs.push_back('{act: ACT_ALLOC, addr: '1});
		pending_reqs.push_back('{act: ACT_FREE, addr: 48'd5});
		pending_reqs.push_back('{act: ACT_FREE, addr: 48'd5});
		pending_reqs.push_back('{act: ACT_FREE, addr: 48'hFFFF_FFFF_FFFF});
		pending_reqs.push_back('{act: ACT_FREE, addr: 48'd17});
		pending_reqs.push_back('{act: ACT_ALLOC, addr: '0});
		pending_reqs.push_back('{act: ACT_FREE, addr: 48'd16});
		push_random(230);

		set_config(8, 16, 128, 48'h1000);
		push_random(250);
		set_config(16383, 2047, 25'h1FF_FFFF, 48'hFFFF_FFFF_FFFF);
		push_random(250);
		set_config(8, 0, 16, 0);
		push_random(25);
		set_config(1, 1, 16, 48'd5000);
		push_random(200);
		set_config(3, 16, 40, ADDR_W'({$urandom, $urandom}));
		push_random(250);
		no_gaps = 1'b1;
		set_config(64, 1024, 65536, ADDR_W'($urandom));
		push_random(250);
		no_gaps = 1'b0;
		set_config($urandom_range(16383), $urandom_range(16, 64),
			$urandom_range(16, 4096), ADDR_W'({$urandom, $urandom}));
		push_random(300);

		wait_idle();
		$display("%0d requests over eight register settings: ok %0d, out of memory %0d",
			items_done, status_seen[ST_OK], status_seen[ST_OUT_OF_MEM]);
		$display("invalid object %0d, double free %0d, %0d mismatches",
			status_seen[ST_INVALID], status_seen[ST_DOUBLE_FREE], fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
